// ===== src/rrss_pkg.sv =====
package rrss_pkg;

    // Process table size and pid width
    localparam int NUM_PROCS = 16;
    localparam int PID_W     = 4;
    localparam int STEP_W    = $clog2(NUM_PROCS + 1);

    localparam logic [PID_W-1:0] FALLBACK_PID = '0;
    localparam logic [15:0]      SLICE_RESET  = 16'd10;

    // Item kinds
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_ADD    = 3'd1;
    localparam logic [2:0] KIND_REMOVE = 3'd2;
    localparam logic [2:0] KIND_YIELD  = 3'd3;
    localparam logic [2:0] KIND_EXIT   = 3'd4;

    // Result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_DUP    = 2'd1;
    localparam logic [1:0] STATUS_ABSENT = 2'd2;

    typedef enum logic [1:0] {
        PS_NONE,
        PS_READY,
        PS_RUNNING,
        PS_ZOMBIE
    } proc_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ENQ,
        ST_UNL,
        ST_UNL_HEAD,
        ST_WALK_ISSUE,
        ST_WALK_CHECK,
        ST_SPLICE,
        ST_SCHED,
        ST_SCHED_REQ,
        ST_SCHED_FIN,
        ST_DONE
    } sched_state_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [PID_W-1:0] pid;
    } sched_in_t;

    typedef struct packed {
        logic             switched;
        logic [PID_W-1:0] running_pid;
        logic [PID_W-1:0] previous_pid;
        logic [1:0]       status;
    } sched_out_t;

endpackage

// ===== src/rrss_link_mem.sv =====
module rrss_link_mem (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [rrss_pkg::PID_W-1:0] wr_addr,
    input  logic [rrss_pkg::PID_W-1:0] wr_data,
    input  logic [rrss_pkg::PID_W-1:0] rd_addr,
    output logic [rrss_pkg::PID_W-1:0] rd_data
);
    import rrss_pkg::*;

    // Successor links of the ready queue, one read and one write port
    logic [PID_W-1:0] mem [NUM_PROCS];
    logic [PID_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/round_robin_slice_scheduler_top.sv =====
// Round-robin time-slice scheduler over a linked ready queue; one item in flight.
// An add enqueues directly; a remove at the head unlinks it there, any other remove walks the
// queue one link read at a time; a schedule may requeue the current pid before it switches.
// A new beat is taken only after the previous result has loaded; a stalled output holds it off.
// Reset (rst_n, async low): pid 0 current, ready and queued; slice length 10.
module round_robin_slice_scheduler_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rrss_pkg::sched_in_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rrss_pkg::sched_out_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);
    import rrss_pkg::*;

    // Control state
    sched_state_t     state_reg, state_next;
    logic [PID_W-1:0] head_reg, head_next;
    logic [PID_W-1:0] tail_reg, tail_next;
    logic             nonempty_reg, nonempty_next;
    logic [PID_W-1:0] current_reg, current_next;
    logic [15:0]      slice_count_reg, slice_count_next;
    logic [15:0]      slice_length_reg;
    logic [NUM_PROCS-1:0] queued_reg;
    proc_state_t      pstate_reg [NUM_PROCS];
    logic             out_valid_reg, out_valid_next;

    // Working registers of the item in flight
    logic [2:0]       kind_reg, kind_next;
    logic [PID_W-1:0] pid_reg, pid_next;
    logic [PID_W-1:0] before_reg, before_next;
    logic [1:0]       status_reg, status_next;
    logic [PID_W-1:0] op_pid_reg, op_pid_next;
    logic [PID_W-1:0] nxt_reg, nxt_next;
    logic [PID_W-1:0] cur_reg, cur_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic             sched_flag_reg, sched_flag_next;
    sched_out_t       out_data_reg, out_data_next;

    // Table access and memory port
    logic [PID_W-1:0] sel_pid;
    proc_state_t      ps_rd;
    logic             q_rd;
    logic             ps_we, q_we, q_wdata;
    proc_state_t      ps_wdata;
    logic             mem_we;
    logic [PID_W-1:0] mem_waddr, mem_wdata, mem_raddr, mem_rdata;

    // Shared conditions
    logic [15:0]      slice_inc;
    logic             pid_valid, unl_absent, at_head, is_tail, walk_more, walk_hit, out_free;
    sched_state_t     after_unl;

    rrss_link_mem u_link_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // One table address per state
    always_comb
    begin
        unique case (state_reg)
            ST_EXEC, ST_SCHED_REQ: sel_pid = current_reg;
            ST_SCHED_FIN:          sel_pid = nxt_reg;
            default:               sel_pid = op_pid_reg;
        endcase
    end

    assign ps_rd = pstate_reg[sel_pid];
    assign q_rd  = queued_reg[sel_pid];

    assign slice_inc  = slice_count_reg + 16'd1;
    assign pid_valid  = ({1'b0, pid_reg} < NUM_PROCS[PID_W:0]);
    assign unl_absent = !nonempty_reg || !q_rd;
    assign at_head    = (head_reg == op_pid_reg);
    assign is_tail    = (tail_reg == op_pid_reg);
    assign walk_more  = ({1'b0, steps_reg} < NUM_PROCS[STEP_W:0]) && (cur_reg != tail_reg);
    assign walk_hit   = (mem_rdata == op_pid_reg);
    assign after_unl  = sched_flag_reg ? ST_SCHED_REQ : ST_DONE;
    assign out_free   = !(out_valid_reg && out_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (kind_reg) inside
                    KIND_TICK:   state_next = (slice_inc >= slice_length_reg) ? ST_SCHED : ST_DONE;
                    KIND_ADD:    state_next = pid_valid ? ST_ENQ : ST_DONE;
                    KIND_REMOVE: state_next = pid_valid ? ST_UNL : ST_DONE;
                    KIND_YIELD, KIND_EXIT: state_next = ST_SCHED;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_ENQ:        state_next = sched_flag_reg ? ST_SCHED_FIN : ST_DONE;
            ST_UNL:
            begin
                if (unl_absent)
                begin
                    state_next = after_unl;
                end
                else if (at_head)
                begin
                    state_next = is_tail ? after_unl : ST_UNL_HEAD;
                end
                else
                begin
                    state_next = ST_WALK_ISSUE;
                end
            end
            ST_UNL_HEAD:   state_next = after_unl;
            ST_WALK_ISSUE: state_next = walk_more ? ST_WALK_CHECK : after_unl;
            ST_WALK_CHECK:
            begin
                if (walk_hit)
                begin
                    state_next = is_tail ? after_unl : ST_SPLICE;
                end
                else
                begin
                    state_next = ST_WALK_ISSUE;
                end
            end
            ST_SPLICE:     state_next = after_unl;
            ST_SCHED:      state_next = nonempty_reg ? ST_UNL : ST_SCHED_REQ;
            ST_SCHED_REQ:  state_next = (ps_rd == PS_RUNNING) ? ST_ENQ : ST_SCHED_FIN;
            ST_SCHED_FIN:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Datapath and table updates
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        nonempty_next    = nonempty_reg;
        current_next     = current_reg;
        slice_count_next = slice_count_reg;
        kind_next        = kind_reg;
        pid_next         = pid_reg;
        before_next      = before_reg;
        status_next      = status_reg;
        op_pid_next      = op_pid_reg;
        nxt_next         = nxt_reg;
        cur_next         = cur_reg;
        steps_next       = steps_reg;
        sched_flag_next  = sched_flag_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && out_stall;
        ps_we            = 1'b0;
        ps_wdata         = PS_NONE;
        q_we             = 1'b0;
        q_wdata          = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = tail_reg;
        mem_wdata        = op_pid_reg;
        mem_raddr        = op_pid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                kind_next       = in_data.kind;
                pid_next        = in_data.pid;
                before_next     = current_reg;
                status_next     = STATUS_OK;
                sched_flag_next = 1'b0;
            end
            ST_EXEC:
            begin
                op_pid_next = pid_reg;
                case (kind_reg)
                    KIND_TICK:
                    begin
                        slice_count_next = (slice_inc >= slice_length_reg) ? 16'd0 : slice_inc;
                    end
                    KIND_REMOVE:
                    begin
                        if (!pid_valid)
                        begin
                            status_next = STATUS_ABSENT;
                        end
                    end
                    KIND_EXIT:
                    begin
                        ps_we    = 1'b1;
                        ps_wdata = PS_ZOMBIE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_ENQ:
            begin
                if (q_rd)
                begin
                    if (!sched_flag_reg)
                    begin
                        status_next = STATUS_DUP;
                    end
                end
                else
                begin
                    ps_we    = 1'b1;
                    ps_wdata = PS_READY;
                    q_we     = 1'b1;
                    q_wdata  = 1'b1;
                    if (nonempty_reg)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        head_next = op_pid_reg;
                    end
                    tail_next     = op_pid_reg;
                    nonempty_next = 1'b1;
                end
            end
            ST_UNL:
            begin
                cur_next   = head_reg;
                steps_next = '0;
                if (unl_absent)
                begin
                    if (!sched_flag_reg)
                    begin
                        status_next = STATUS_ABSENT;
                    end
                end
                else if (at_head && is_tail)
                begin
                    nonempty_next = 1'b0;
                    q_we          = 1'b1;
                end
            end
            ST_UNL_HEAD:
            begin
                head_next = mem_rdata;
                q_we      = 1'b1;
            end
            ST_WALK_ISSUE:
            begin
                mem_raddr = cur_reg;
                if (!walk_more)
                begin
                    q_we = 1'b1;
                end
            end
            ST_WALK_CHECK:
            begin
                if (walk_hit)
                begin
                    if (is_tail)
                    begin
                        tail_next = cur_reg;
                        q_we      = 1'b1;
                    end
                end
                else
                begin
                    cur_next   = mem_rdata;
                    steps_next = steps_reg + 1'b1;
                end
            end
            ST_SPLICE:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = mem_rdata;
                q_we      = 1'b1;
            end
            ST_SCHED:
            begin
                sched_flag_next = 1'b1;
                nxt_next        = nonempty_reg ? head_reg : FALLBACK_PID;
                op_pid_next     = head_reg;
            end
            ST_SCHED_REQ:
            begin
                op_pid_next = current_reg;
            end
            ST_SCHED_FIN:
            begin
                if (nxt_reg == current_reg)
                begin
                    ps_we    = 1'b1;
                    ps_wdata = PS_RUNNING;
                end
                else
                begin
                    if (ps_rd == PS_READY)
                    begin
                        ps_we    = 1'b1;
                        ps_wdata = PS_RUNNING;
                    end
                    slice_count_next = 16'd0;
                    current_next     = nxt_reg;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.switched     = (current_reg != before_reg);
                    out_data_next.running_pid  = current_reg;
                    out_data_next.previous_pid = before_reg;
                    out_data_next.status       = status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Port outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = out_valid_reg;
        out_data  = out_data_reg;
        cfg_ready = 1'b1;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= FALLBACK_PID;
            tail_reg         <= FALLBACK_PID;
            nonempty_reg     <= 1'b1;
            current_reg      <= FALLBACK_PID;
            slice_count_reg  <= 16'd0;
            slice_length_reg <= SLICE_RESET;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_PROCS; i++)
            begin
                queued_reg[i] <= (i == int'(FALLBACK_PID));
                pstate_reg[i] <= (i == int'(FALLBACK_PID)) ? PS_READY : PS_NONE;
            end
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            nonempty_reg    <= nonempty_next;
            current_reg     <= current_next;
            slice_count_reg <= slice_count_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                slice_length_reg <= cfg_data;
            end
            if (q_we)
            begin
                queued_reg[sel_pid] <= q_wdata;
            end
            if (ps_we)
            begin
                pstate_reg[sel_pid] <= ps_wdata;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        pid_reg        <= pid_next;
        before_reg     <= before_next;
        status_reg     <= status_next;
        op_pid_reg     <= op_pid_next;
        nxt_reg        <= nxt_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        sched_flag_reg <= sched_flag_next;
        out_data_reg   <= out_data_next;
    end

    // An accepted beat always starts execution
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_EXEC)
        else $error("accepted beat did not start execution");

    // Empty queue holds no marks
    a_empty_unmarked: assert property (@(posedge clk) disable iff (!rst_n)
        !nonempty_reg |-> queued_reg == '0)
        else $error("queue empty but a pid is still marked queued");

    // Head and tail of a nonempty queue are marked
    a_ends_marked: assert property (@(posedge clk) disable iff (!rst_n)
        nonempty_reg |-> queued_reg[head_reg] && queued_reg[tail_reg])
        else $error("queue head or tail not marked queued");

endmodule

// ===== sim/round_robin_slice_scheduler_checker.sv =====
`timescale 1ns / 1ps

module round_robin_slice_scheduler_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  rrss_pkg::sched_in_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  rrss_pkg::sched_out_t out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [15:0]          cfg_data,
    output int                   fail_count,
    output int                   pending
);
    import rrss_pkg::*;

    // Shadow scheduler state
    logic [15:0]          slice_len;
    logic [PID_W-1:0]     succ [NUM_PROCS];
    logic [NUM_PROCS-1:0] in_queue;
    proc_state_t          pstate [NUM_PROCS];
    logic [PID_W-1:0]     q_head;
    logic [PID_W-1:0]     q_tail;
    logic                 q_nonempty;
    logic [PID_W-1:0]     cur_pid;
    logic [15:0]          tick_cnt;

    // Results owed by the block, oldest first
    sched_out_t due_results[$];
    sched_out_t want;
    int         errs;

    function automatic void reset_model();
        slice_len = SLICE_RESET;
        for (int p = 0; p < NUM_PROCS; p++)
        begin
            succ[p]   = '0;
            pstate[p] = PS_NONE;
        end
        in_queue               = '0;
        in_queue[FALLBACK_PID] = 1'b1;
        pstate[FALLBACK_PID]   = PS_READY;
        q_head                 = FALLBACK_PID;
        q_tail                 = FALLBACK_PID;
        q_nonempty             = 1'b1;
        cur_pid                = FALLBACK_PID;
        tick_cnt               = '0;
        due_results.delete();
    endfunction

    // Append to the ready queue; 0 if already queued
    function automatic bit ready_append(input logic [PID_W-1:0] p);
        if (in_queue[p])
            return 1'b0;
        pstate[p]   = PS_READY;
        in_queue[p] = 1'b1;
        if (q_nonempty)
            succ[q_tail] = p;
        else
            q_head = p;
        q_tail     = p;
        q_nonempty = 1'b1;
        return 1'b1;
    endfunction

    // Unlink from the ready queue by walking it; 0 if not queued
    function automatic bit ready_unlink(input logic [PID_W-1:0] p);
        logic [PID_W-1:0] walk;
        bit               found;
        int               hops;
        if (!q_nonempty || !in_queue[p])
            return 1'b0;
        if (q_head == p)
        begin
            if (q_tail == p)
                q_nonempty = 1'b0;
            else
                q_head = succ[p];
        end
        else
        begin
            walk  = q_head;
            found = 1'b0;
            for (hops = 0; hops < NUM_PROCS && !found && walk != q_tail; hops++)
            begin
                if (succ[walk] == p)
                begin
                    if (q_tail == p)
                        q_tail = walk;
                    else
                        succ[walk] = succ[p];
                    found = 1'b1;
                end
                else
                    walk = succ[walk];
            end
        end
        in_queue[p] = 1'b0;
        return 1'b1;
    endfunction

    // Pick the next process: queue head, else pid 0; requeue a running current
    function automatic void run_schedule();
        logic [PID_W-1:0] prev;
        logic [PID_W-1:0] nxt;
        prev = cur_pid;
        nxt  = FALLBACK_PID;
        if (q_nonempty)
        begin
            nxt = q_head;
            void'(ready_unlink(nxt));
        end
        if (pstate[prev] == PS_RUNNING)
            void'(ready_append(prev));
        if (nxt == prev)
        begin
            // same process again: no switch, tick count kept
            pstate[nxt] = PS_RUNNING;
            return;
        end
        if (pstate[nxt] == PS_READY)
            pstate[nxt] = PS_RUNNING;
        tick_cnt = '0;
        cur_pid  = nxt;
    endfunction

    // Advance the shadow state by one input beat, return the result it owes
    function automatic sched_out_t apply_item(input sched_in_t item);
        sched_out_t res;
        res.previous_pid = cur_pid;
        res.status       = STATUS_OK;
        case (item.kind)
            KIND_TICK:
            begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= slice_len)
                begin
                    tick_cnt = '0;
                    run_schedule();
                end
            end
            KIND_ADD:
            begin
                if (!ready_append(item.pid))
                    res.status = STATUS_DUP;
            end
            KIND_REMOVE:
            begin
                if (!ready_unlink(item.pid))
                    res.status = STATUS_ABSENT;
            end
            KIND_YIELD:
                run_schedule();
            KIND_EXIT:
            begin
                pstate[cur_pid] = PS_ZOMBIE;
                run_schedule();
            end
            default:
                ;
        endcase
        res.running_pid = cur_pid;
        res.switched    = (cur_pid != res.previous_pid);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [3:0] exp_val,
                                        input logic [3:0] act_val);
        if (act_val !== exp_val)
        begin
            errs++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val,
                     act_val);
        end
    endfunction

    // Watch all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
            errs = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                slice_len = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    errs++;
                    $display("%0t: result beat with nothing expected: expected none, got %p",
                             $time, out_data);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("switched", 4'(want.switched), 4'(out_data.switched));
                    check_field("running_pid", want.running_pid, out_data.running_pid);
                    check_field("previous_pid", want.previous_pid, out_data.previous_pid);
                    check_field("status", 4'(want.status), 4'(out_data.status));
                end
            end
            if (in_valid && !in_stall)
                due_results.push_back(apply_item(in_data));
            fail_count <= errs;
            pending    <= due_results.size();
        end
    end

endmodule

// ===== sim/tb_round_robin_slice_scheduler_top.sv =====
`timescale 1ns / 1ps

module tb_round_robin_slice_scheduler_top;
    import rrss_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int IDLE_LIMIT   = 5000;  // cycles with no beat on any channel
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int SETTLE       = 48;    // idle wait after the last owed result
    localparam int PHASE_ITEMS  = 260;
    localparam int NUM_PHASES   = 7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    sched_in_t   in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    sched_out_t  out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int hold_asks = 0;

    // Directed opening sequence, run at the reset slice length
    sched_in_t opening[$] = '{
        '{KIND_SPARE_HI, 4'd15},
        '{KIND_SPARE_LO, 4'd0},
        '{KIND_ADD,      4'd0},   // pid 0 already queued
        '{KIND_REMOVE,   4'd9},   // not queued
        '{KIND_ADD,      4'd15},
        '{KIND_ADD,      4'd1},
        '{KIND_ADD,      4'd8},
        '{KIND_ADD,      4'd6},
        '{KIND_REMOVE,   4'd1},   // middle of the queue
        '{KIND_REMOVE,   4'd6},   // tail, found by walking
        '{KIND_YIELD,    4'd0},   // head is current: no switch
        '{KIND_YIELD,    4'd5},
        '{KIND_REMOVE,   4'd15},  // current, not queued
        '{KIND_ADD,      4'd15},
        '{KIND_REMOVE,   4'd15},  // current while queued
        '{KIND_ADD,      4'd15},
        '{KIND_EXIT,     4'd0},   // exits while still queued
        '{KIND_TICK,     4'd0},
        '{KIND_TICK,     4'd0},
        '{KIND_TICK,     4'd0},
        '{KIND_REMOVE,   4'd0},   // head
        '{KIND_REMOVE,   4'd15},  // last one: queue empties
        '{KIND_YIELD,    4'd0},   // empty queue: falls back to pid 0
        '{KIND_EXIT,     4'd0},
        '{KIND_EXIT,     4'd0}
    };

    logic [15:0] slice_plan [NUM_PHASES] = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd0,
                                             16'd3, 16'd10};

    always #10 clk = ~clk;

    round_robin_slice_scheduler_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    round_robin_slice_scheduler_checker i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one beat and hold it until accepted; valid stays high afterwards
    task automatic send_beat(input sched_in_t item);
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_slice(input logic [15:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every owed result, then let the block settle back to idle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Weighted random item: mostly ticks and queue traffic, a few spare kinds
    function automatic sched_in_t rand_item();
        sched_in_t   item;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35)
            item.kind = KIND_TICK;
        else if (r < 60)
            item.kind = KIND_ADD;
        else if (r < 76)
            item.kind = KIND_REMOVE;
        else if (r < 87)
            item.kind = KIND_YIELD;
        else if (r < 96)
            item.kind = KIND_EXIT;
        else
            item.kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        item.pid = PID_W'($urandom_range(NUM_PROCS - 1));
        return item;
    endfunction

    // Receiver: stall pattern changes mode now and then, plus requested hold-offs
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int hold_done;
        int cyc;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 0;
        cyc       = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_asks != hold_done)
            begin
                hold_done++;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(3);
                    mode_left = $urandom_range(256, 32);
                end
                mode_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(99) < 30);
                    2:       out_stall <= ($urandom_range(99) < 75);
                    default: out_stall <= ((cyc % 7) < 3);
                endcase
            end
            cyc++;
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall) ||
                           (cfg_valid && cfg_ready)))
                idle_cycles++;
            else
                idle_cycles = 0;
        end
        $display("[round_robin_slice_scheduler_top] ERROR");
        $finish;
    end

    // Stimulus
    initial
    begin
        int  burst_left;
        bit  gaps_on;
        bit  hold_phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_beat(opening[i]);
        in_valid <= 1'b0;
        wait_drained();

        slice_plan[4] = 16'($urandom_range(40, 4));
        burst_left    = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_slice(slice_plan[ph]);
            gaps_on    = ($urandom_range(3) != 0);
            hold_phase = (ph == 1) || ($urandom_range(2) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_beat(rand_item());
                // long receiver hold-off while the sender keeps offering
                if (hold_phase && n == PHASE_ITEMS / 3)
                    hold_asks <= hold_asks + 1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(24, 1);
                    if (gaps_on)
                    begin
                        in_valid <= 1'b0;
                        repeat ($urandom_range(8, 1)) @(posedge clk);
                    end
                end
                else
                    burst_left--;
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        if (fail_count == 0)
            $display("[round_robin_slice_scheduler_top] OK");
        else
            $display("[round_robin_slice_scheduler_top] ERROR");
        $finish;
    end

endmodule
